FILE: hdl/dhid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhid_pkg
// Shared types and constants of the differential Huffman image decoder.
// ----------------------------------------------------------------------------
package dhid_pkg;

  // Default sizing
  localparam int DEF_MAX_ENTRIES  = 512;
  localparam int DEF_MAX_CODE_LEN = 31;
  localparam int DEF_DIM_BITS     = 32;

  // Fixed field widths of the file format
  localparam int SYM_W   = 9;
  localparam int LEN_W   = 5;
  localparam int CODE_W  = 32;   // canonical code counter
  localparam int CV_W    = 31;   // collected code bits
  localparam int CLEN_W  = 6;
  localparam int CNT_W   = 9;    // table count field
  localparam int IDX_W   = 10;
  localparam int FACC_W  = 14;
  localparam int DIMA_W  = 32;
  localparam int ENTRY_W = CODE_W + LEN_W + SYM_W;

  // Result status codes
  localparam logic [1:0] ST_PIXEL   = 2'd0;
  localparam logic [1:0] ST_NOMATCH = 2'd1;
  localparam logic [1:0] ST_ONESYM  = 2'd2;

  // File parse phase
  typedef enum logic [2:0] {
    PH_MAGIC,
    PH_DIMS,
    PH_COUNT,
    PH_TABLE,
    PH_PIXELS,
    PH_IDLE
  } phase_t;

  // Bit sequencer state
  typedef enum logic [2:0] {
    C_IDLE,
    C_BIT,
    C_CANON,
    C_SCAN,
    C_CMP,
    C_NEXT,
    C_FLUSH
  } ctl_t;

endpackage

FILE: hdl/dhid_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhid_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dhid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/diff_huffman_image_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diff_huffman_image_decoder
// Parses a compressed grey image byte by byte: header, canonical Huffman
// table, then DPCM pixels decoded one code bit at a time.
// ----------------------------------------------------------------------------
//  channel | dir | tdata            | tuser                      | tlast
//  in_     | in  | data_byte[7:0]   | start_of_file              | -
//  out_    | out | pixel[7:0]       | status[1:0], image_done[2] | last_of_run
//
//  Header bytes are taken in the idle state. A bit-stream byte passes an
//  accept state, then each bit in turn, then a flush state; a table entry
//  adds one canonical length step at a time, then a write, and during pixels
//  the search visits table entries one after another (one RAM read port).
//  Reset clears all control state; table memory is undefined until loaded.
//  Stalls: a result waits while pending and output registers are both full,
//  and a byte ends only once its last result sits in the output register.
// ----------------------------------------------------------------------------
module diff_huffman_image_decoder
  import dhid_pkg::*;
#(
  parameter int MAX_ENTRIES  = DEF_MAX_ENTRIES,
  parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN,
  parameter int DIM_BITS     = DEF_DIM_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // data_byte
  input  logic       in_tuser,   // start_of_file
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // pixel
  output logic [2:0] out_tuser,  // status[1:0], image_done[2]
  output logic       out_tlast   // last_of_run
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam logic [IDX_W-1:0] MAXE   = IDX_W'(MAX_ENTRIES);
  localparam logic [LEN_W-1:0] MAXLEN = LEN_W'(MAX_CODE_LEN);

  ctl_t st_r, st_nxt;
  phase_t ph_r, ph_nxt;
  logic [2:0]          hbc_r, hbc_nxt;
  logic [DIMA_W-1:0]   dacc_r, dacc_nxt;
  logic [DIM_BITS-1:0] width_r, width_nxt, height_r, height_nxt;
  logic [FACC_W-1:0]   facc_r, facc_nxt;
  logic [3:0]          fcnt_r, fcnt_nxt;
  logic [CNT_W-1:0]    total_r, total_nxt;
  logic [IDX_W-1:0]    stored_r, stored_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [SYM_W-1:0]    sym_r, sym_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [CODE_W-1:0]   ncode_r, ncode_nxt;
  logic [LEN_W-1:0]    clen_canon_r, clen_canon_nxt;
  logic [CV_W-1:0]     cv_r, cv_nxt;
  logic [CLEN_W-1:0]   clen_r, clen_nxt;
  logic [DIM_BITS-1:0] row_r, row_nxt, col_r, col_nxt;
  logic [7:0]          left_r, left_nxt, rstart_r, rstart_nxt;
  logic [7:0]          byte_r, byte_nxt;
  logic [2:0]          bc_r, bc_nxt;
  logic                pend_v_r, pend_v_nxt;
  logic [7:0]          pend_pix_r, pend_pix_nxt;
  logic [1:0]          pend_st_r, pend_st_nxt;
  logic                pend_done_r, pend_done_nxt;
  logic                out_v_r, out_v_nxt;
  logic [7:0]          out_pix_r, out_pix_nxt;
  logic [1:0]          out_st_r, out_st_nxt;
  logic                out_done_r, out_done_nxt;
  logic                out_last_r, out_last_nxt;

  // Table memory port
  logic               ram_we;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  // Result hand-off
  logic       emit, flush_push, can_emit;
  logic [7:0] emit_pix;
  logic [1:0] emit_st;
  logic       emit_done;

  // Combinational helpers
  logic                bit_in;
  logic [DIMA_W-1:0]   dacc_sh;
  logic [FACC_W-1:0]   facc_sh;
  logic [LEN_W-1:0]    fld_len;
  logic [SYM_W-1:0]    rd_sym;
  logic [LEN_W-1:0]    rd_len;
  logic [CODE_W-1:0]   rd_code;
  logic [7:0]          base_pix, sum_pix;
  logic [DIM_BITS-1:0] col_inc, row_inc;
  logic                col_wrap, img_done;
  logic [IDX_W-1:0]    idx_inc;

  dhid_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(idx_r[AW-1:0]),
    .wdata(ram_wdata),
    .raddr(idx_r[AW-1:0]),
    .rdata(ram_rdata)
  );

  assign ram_wdata = {ncode_r, len_r, sym_r};
  assign rd_sym    = ram_rdata[SYM_W-1:0];
  assign rd_len    = ram_rdata[SYM_W +: LEN_W];
  assign rd_code   = ram_rdata[SYM_W+LEN_W +: CODE_W];

  assign bit_in   = byte_r[7];
  assign dacc_sh  = {in_tdata, dacc_r[DIMA_W-1:8]};
  assign facc_sh  = {facc_r[FACC_W-2:0], bit_in};
  assign fld_len  = (facc_sh[LEN_W-1:0] > MAXLEN) ? MAXLEN : facc_sh[LEN_W-1:0];
  assign base_pix = (col_r == '0) ? rstart_r : left_r;
  assign sum_pix  = rd_sym[7:0] + base_pix;
  assign col_inc  = col_r + 1'b1;
  assign row_inc  = row_r + 1'b1;
  assign col_wrap = (col_inc == width_r);
  assign img_done = col_wrap && (row_inc == height_r);
  assign idx_inc  = idx_r + 1'b1;
  assign can_emit = !pend_v_r || !out_v_r || out_tready;

  assign in_tready  = (st_r == C_IDLE);
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_pix_r;
  assign out_tuser  = {out_done_r, out_st_r};
  assign out_tlast  = out_last_r;

  // Sequencer: next state and datapath updates
  always_comb begin
    st_nxt         = st_r;
    ph_nxt         = ph_r;
    hbc_nxt        = hbc_r;
    dacc_nxt       = dacc_r;
    width_nxt      = width_r;
    height_nxt     = height_r;
    facc_nxt       = facc_r;
    fcnt_nxt       = fcnt_r;
    total_nxt      = total_r;
    stored_nxt     = stored_r;
    idx_nxt        = idx_r;
    sym_nxt        = sym_r;
    len_nxt        = len_r;
    ncode_nxt      = ncode_r;
    clen_canon_nxt = clen_canon_r;
    cv_nxt         = cv_r;
    clen_nxt       = clen_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    left_nxt       = left_r;
    rstart_nxt     = rstart_r;
    byte_nxt       = byte_r;
    bc_nxt         = bc_r;
    ram_we         = 1'b0;
    emit           = 1'b0;
    emit_pix       = '0;
    emit_st        = ST_PIXEL;
    emit_done      = 1'b0;
    flush_push     = 1'b0;

    unique case (st_r)
      C_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser) begin
            // restart: clear parse state, this byte is magic byte 0
            ph_nxt         = PH_MAGIC;
            hbc_nxt        = 3'd1;
            dacc_nxt       = '0;
            width_nxt      = '0;
            height_nxt     = '0;
            facc_nxt       = '0;
            fcnt_nxt       = '0;
            total_nxt      = '0;
            stored_nxt     = '0;
            idx_nxt        = '0;
            ncode_nxt      = '0;
            clen_canon_nxt = '0;
            cv_nxt         = '0;
            clen_nxt       = '0;
            row_nxt        = '0;
            col_nxt        = '0;
            left_nxt       = '0;
            rstart_nxt     = '0;
          end else begin
            unique case (ph_r)
              PH_MAGIC: begin
                hbc_nxt = hbc_r + 1'b1;
                if (hbc_r == 3'd7) begin
                  ph_nxt = PH_DIMS;
                end
              end
              PH_DIMS: begin
                // little-endian bytes shift in from the top
                dacc_nxt = dacc_sh;
                hbc_nxt  = hbc_r + 1'b1;
                if (hbc_r == 3'd3) begin
                  width_nxt = dacc_sh[DIM_BITS-1:0];
                end
                if (hbc_r == 3'd7) begin
                  height_nxt = dacc_sh[DIM_BITS-1:0];
                  facc_nxt   = '0;
                  fcnt_nxt   = '0;
                  ph_nxt     = PH_COUNT;
                end
              end
              PH_COUNT, PH_TABLE, PH_PIXELS: begin
                byte_nxt = in_tdata;
                bc_nxt   = 3'd7;
                st_nxt   = C_BIT;
              end
              default: ;  // idle phase: byte ignored
            endcase
          end
        end
      end

      C_BIT: begin
        st_nxt = C_NEXT;
        if (ph_r == PH_COUNT || ph_r == PH_TABLE) begin
          facc_nxt = facc_sh;
          fcnt_nxt = fcnt_r + 1'b1;
          if (ph_r == PH_COUNT && fcnt_r == 4'd8) begin
            total_nxt  = facc_sh[CNT_W-1:0];
            stored_nxt = ({1'b0, facc_sh[CNT_W-1:0]} > MAXE) ? MAXE
                                                             : {1'b0, facc_sh[CNT_W-1:0]};
            facc_nxt   = '0;
            fcnt_nxt   = '0;
            idx_nxt    = '0;
            if (facc_sh[CNT_W-1:0] == '0) begin
              cv_nxt   = '0;
              clen_nxt = '0;
              if (width_r != '0 && height_r != '0) begin
                ph_nxt = PH_PIXELS;
                st_nxt = C_SCAN;
              end else begin
                ph_nxt = PH_IDLE;
              end
            end else begin
              ph_nxt = PH_TABLE;
            end
          end else if (ph_r == PH_TABLE && fcnt_r == 4'd13) begin
            sym_nxt  = facc_sh[FACC_W-1:LEN_W];
            len_nxt  = fld_len;
            facc_nxt = '0;
            fcnt_nxt = '0;
            st_nxt   = C_CANON;
          end
        end else if (ph_r == PH_PIXELS) begin
          cv_nxt   = {cv_r[CV_W-2:0], bit_in};
          clen_nxt = clen_r + 1'b1;
          st_nxt   = C_SCAN;
        end
      end

      C_CANON: begin
        // lengthen the canonical code one bit per cycle
        if (clen_canon_r < len_r) begin
          ncode_nxt      = {ncode_r[CODE_W-2:0], 1'b0};
          clen_canon_nxt = clen_canon_r + 1'b1;
        end else begin
          ram_we    = (idx_r < MAXE);
          ncode_nxt = ncode_r + 1'b1;
          idx_nxt   = idx_inc;
          st_nxt    = C_NEXT;
          if (idx_inc >= {1'b0, total_r}) begin
            idx_nxt  = '0;
            cv_nxt   = '0;
            clen_nxt = '0;
            if (width_r != '0 && height_r != '0) begin
              ph_nxt = PH_PIXELS;
              st_nxt = C_SCAN;
            end else begin
              ph_nxt = PH_IDLE;
            end
          end
        end
      end

      C_SCAN: begin
        // RAM read of idx is issued here
        if (idx_r >= stored_r) begin
          if (can_emit) begin
            emit    = 1'b1;
            emit_st = ST_NOMATCH;
            ph_nxt  = PH_IDLE;
            st_nxt  = C_NEXT;
          end
        end else begin
          st_nxt = C_CMP;
        end
      end

      C_CMP: begin
        if ({1'b0, rd_len} > clen_r) begin
          st_nxt = C_NEXT;  // need more bits
        end else if (rd_code == {1'b0, cv_r}) begin
          if (can_emit) begin
            emit = 1'b1;
            if (clen_r == '0) begin
              emit_st = ST_ONESYM;
              ph_nxt  = PH_IDLE;
              st_nxt  = C_NEXT;
            end else begin
              emit_pix  = sum_pix;
              emit_done = img_done;
              left_nxt  = sum_pix;
              if (col_r == '0) begin
                rstart_nxt = sum_pix;
              end
              if (col_wrap) begin
                col_nxt = '0;
                row_nxt = row_inc;
              end else begin
                col_nxt = col_inc;
              end
              idx_nxt  = '0;
              cv_nxt   = '0;
              clen_nxt = '0;
              if (img_done) begin
                ph_nxt = PH_IDLE;
                st_nxt = C_NEXT;
              end else begin
                st_nxt = C_SCAN;
              end
            end
          end
        end else begin
          idx_nxt = idx_inc;
          st_nxt  = C_SCAN;
        end
      end

      C_NEXT: begin
        if (bc_r == 3'd0 || ph_r == PH_IDLE) begin
          st_nxt = C_FLUSH;
        end else begin
          byte_nxt = {byte_r[6:0], 1'b0};
          bc_nxt   = bc_r - 1'b1;
          st_nxt   = C_BIT;
        end
      end

      C_FLUSH: begin
        // last result of the byte carries last_of_run
        if (!pend_v_r) begin
          st_nxt = C_IDLE;
        end else if (!out_v_r || out_tready) begin
          flush_push = 1'b1;
          st_nxt     = C_IDLE;
        end
      end

      default: st_nxt = C_IDLE;
    endcase
  end

  // Pending result and output register
  always_comb begin
    pend_v_nxt    = pend_v_r;
    pend_pix_nxt  = pend_pix_r;
    pend_st_nxt   = pend_st_r;
    pend_done_nxt = pend_done_r;
    out_v_nxt     = out_v_r && !out_tready;
    out_pix_nxt   = out_pix_r;
    out_st_nxt    = out_st_r;
    out_done_nxt  = out_done_r;
    out_last_nxt  = out_last_r;
    if ((emit && pend_v_r) || flush_push) begin
      out_v_nxt    = 1'b1;
      out_pix_nxt  = pend_pix_r;
      out_st_nxt   = pend_st_r;
      out_done_nxt = pend_done_r;
      out_last_nxt = flush_push;
      pend_v_nxt   = 1'b0;
    end
    if (emit) begin
      pend_v_nxt    = 1'b1;
      pend_pix_nxt  = emit_pix;
      pend_st_nxt   = emit_st;
      pend_done_nxt = emit_done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= C_IDLE;
      ph_r         <= PH_MAGIC;
      hbc_r        <= '0;
      dacc_r       <= '0;
      width_r      <= '0;
      height_r     <= '0;
      facc_r       <= '0;
      fcnt_r       <= '0;
      total_r      <= '0;
      stored_r     <= '0;
      idx_r        <= '0;
      ncode_r      <= '0;
      clen_canon_r <= '0;
      cv_r         <= '0;
      clen_r       <= '0;
      row_r        <= '0;
      col_r        <= '0;
      left_r       <= '0;
      rstart_r     <= '0;
      bc_r         <= '0;
      pend_v_r     <= 1'b0;
      out_v_r      <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      ph_r         <= ph_nxt;
      hbc_r        <= hbc_nxt;
      dacc_r       <= dacc_nxt;
      width_r      <= width_nxt;
      height_r     <= height_nxt;
      facc_r       <= facc_nxt;
      fcnt_r       <= fcnt_nxt;
      total_r      <= total_nxt;
      stored_r     <= stored_nxt;
      idx_r        <= idx_nxt;
      ncode_r      <= ncode_nxt;
      clen_canon_r <= clen_canon_nxt;
      cv_r         <= cv_nxt;
      clen_r       <= clen_nxt;
      row_r        <= row_nxt;
      col_r        <= col_nxt;
      left_r       <= left_nxt;
      rstart_r     <= rstart_nxt;
      bc_r         <= bc_nxt;
      pend_v_r     <= pend_v_nxt;
      out_v_r      <= out_v_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    sym_r       <= sym_nxt;
    len_r       <= len_nxt;
    byte_r      <= byte_nxt;
    pend_pix_r  <= pend_pix_nxt;
    pend_st_r   <= pend_st_nxt;
    pend_done_r <= pend_done_nxt;
    out_pix_r   <= out_pix_nxt;
    out_st_r    <= out_st_nxt;
    out_done_r  <= out_done_nxt;
    out_last_r  <= out_last_nxt;
  end

endmodule

FILE: hdl/dhid_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhid_chk
// Port-level checks of the image decoder, bound to the top level.
// ----------------------------------------------------------------------------
module dhid_chk
  import dhid_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [2:0] out_tuser,
  input logic       out_tlast
);

  // stalled item holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled output item changed");

  // error items carry a zero pixel and no image end
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] != ST_PIXEL |-> out_tdata == 8'd0 && !out_tuser[2])
    else $error("error item with pixel or image end");

  // an error ends the byte's run
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] != ST_PIXEL |-> out_tlast)
    else $error("error item not last of run");

  // the last pixel ends the byte's run
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tlast && out_tuser[1:0] == ST_PIXEL)
    else $error("image end not last of run");

endmodule

bind diff_huffman_image_decoder dhid_chk u_dhid_chk (.*);

FILE: bench/dhid_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhid_scoreboard
// Watches both streams of the image decoder, predicts the result items of
// every accepted byte and compares them in order with what comes out.
// ----------------------------------------------------------------------------
module dhid_scoreboard
  import dhid_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,   // data_byte
  input  logic       in_tuser,   // start_of_file
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,  // pixel
  input  logic [2:0] out_tuser,  // status[1:0], image_done[2]
  input  logic       out_tlast,  // last_of_run
  output int         errors,
  output int         pending
);

  localparam int TBL_DEPTH = DEF_MAX_ENTRIES;

  typedef struct packed {
    logic [7:0] pix;
    logic [1:0] st;
    logic       done;
    logic       last;
  } pix_res_t;

  pix_res_t expected_pix_q[$];
  pix_res_t byte_res_q[$];

  // decoder state mirror
  phase_t      phase;
  int unsigned hdr_cnt;
  logic [31:0] img_w, img_h;
  logic [13:0] field_acc;
  int unsigned field_bits;
  int unsigned entry_total, entry_idx;
  logic [8:0]  sym_mem  [TBL_DEPTH];
  logic [4:0]  len_mem  [TBL_DEPTH];
  logic [31:0] code_mem [TBL_DEPTH];
  logic [31:0] next_code;
  int unsigned canon_len;
  logic [30:0] code_val;
  int unsigned code_len;
  logic [31:0] row_cnt, col_cnt;
  logic [7:0]  left_pix, row_start_pix;

  task automatic clear_decoder();
    phase = PH_MAGIC;
    hdr_cnt = 0;
    img_w = '0;
    img_h = '0;
    field_acc = '0;
    field_bits = 0;
    entry_total = 0;
    entry_idx = 0;
    next_code = '0;
    canon_len = 0;
    code_val = '0;
    code_len = 0;
    row_cnt = '0;
    col_cnt = '0;
    left_pix = '0;
    row_start_pix = '0;
  endtask

  task automatic emit(logic [7:0] pix, logic [1:0] st, logic done);
    byte_res_q.insert(byte_res_q.size(),
                      pix_res_t'{pix: pix, st: st, done: done, last: 1'b0});
  endtask

  task automatic abort_image(logic [1:0] st);
    emit(8'd0, st, 1'b0);
    phase = PH_IDLE;
  endtask

  // linear search over the loaded entries for the bits collected so far
  task automatic search_table();
    int unsigned total;
    logic [7:0]  p;
    logic        done;
    total = (entry_total < TBL_DEPTH) ? entry_total : TBL_DEPTH;
    while (entry_idx < total) begin
      if (len_mem[entry_idx] > code_len) return;
      if (code_mem[entry_idx] == {1'b0, code_val}) begin
        if (code_len == 0) begin
          abort_image(ST_ONESYM);
          return;
        end
        if (col_cnt == 0) begin
          p = sym_mem[entry_idx][7:0] + row_start_pix;
          row_start_pix = p;
        end else begin
          p = sym_mem[entry_idx][7:0] + left_pix;
        end
        left_pix = p;
        col_cnt++;
        if (col_cnt >= img_w) begin
          col_cnt = 0;
          row_cnt++;
        end
        done = (row_cnt >= img_h);
        emit(p, ST_PIXEL, done);
        entry_idx = 0;
        code_val = '0;
        code_len = 0;
        if (done) begin
          phase = PH_IDLE;
          return;
        end
      end else begin
        entry_idx++;
      end
    end
    abort_image(ST_NOMATCH);
  endtask

  task automatic start_pixels();
    entry_idx = 0;
    code_val = '0;
    code_len = 0;
    if (img_w == 0 || row_cnt >= img_h) begin
      phase = PH_IDLE;
      return;
    end
    phase = PH_PIXELS;
    search_table();
  endtask

  task automatic shift_bit(logic b);
    logic [4:0] len;
    if (phase == PH_COUNT || phase == PH_TABLE) begin
      field_acc = {field_acc[12:0], b};
      field_bits++;
      if (phase == PH_COUNT && field_bits == 9) begin
        entry_total = 32'(field_acc[8:0]);
        field_acc = '0;
        field_bits = 0;
        entry_idx = 0;
        if (entry_total == 0) start_pixels();
        else phase = PH_TABLE;
      end else if (phase == PH_TABLE && field_bits == 14) begin
        len = field_acc[4:0];
        if (len > DEF_MAX_CODE_LEN) len = 5'(DEF_MAX_CODE_LEN);
        while (canon_len < len) begin
          next_code = next_code << 1;
          canon_len++;
        end
        if (entry_idx < TBL_DEPTH) begin
          sym_mem[entry_idx]  = field_acc[13:5];
          len_mem[entry_idx]  = len;
          code_mem[entry_idx] = next_code;
        end
        field_acc = '0;
        field_bits = 0;
        next_code++;
        entry_idx++;
        if (entry_idx >= entry_total) start_pixels();
      end
    end else if (phase == PH_PIXELS) begin
      code_val = {code_val[29:0], b};
      code_len++;
      search_table();
    end
  endtask

  task automatic decode_byte(logic [7:0] b, logic sof);
    int k;
    if (sof) clear_decoder();
    if (phase == PH_MAGIC) begin
      hdr_cnt++;
      if (hdr_cnt >= 8) begin
        hdr_cnt = 0;
        phase = PH_DIMS;
      end
    end else if (phase == PH_DIMS) begin
      if (hdr_cnt < 4) img_w |= 32'(b) << (8 * (hdr_cnt % 4));
      else img_h |= 32'(b) << (8 * (hdr_cnt % 4));
      hdr_cnt++;
      if (hdr_cnt >= 8) begin
        hdr_cnt = 0;
        field_acc = '0;
        field_bits = 0;
        phase = PH_COUNT;
      end
    end else begin
      for (k = 7; k >= 0 && phase != PH_IDLE; k--) shift_bit(b[k]);
    end
    if (byte_res_q.size() > 0) byte_res_q[$].last = 1'b1;
    foreach (byte_res_q[i]) expected_pix_q.insert(expected_pix_q.size(), byte_res_q[i]);
    byte_res_q.delete();
  endtask

  task automatic check_result();
    pix_res_t got, want;
    got = '{pix: out_tdata, st: out_tuser[1:0], done: out_tuser[2], last: out_tlast};
    if (expected_pix_q.size() == 0) begin
      $display("%0t: unexpected result pix=%0d st=%0d done=%0b last=%0b",
               $time, got.pix, got.st, got.done, got.last);
      errors++;
      return;
    end
    want = expected_pix_q.pop_front();
    if (got != want) begin
      $display("%0t: mismatch expected pix=%0d st=%0d done=%0b last=%0b",
               $time, want.pix, want.st, want.done, want.last);
      $display("%0t:          actual   pix=%0d st=%0d done=%0b last=%0b",
               $time, got.pix, got.st, got.done, got.last);
      errors++;
    end
  endtask

  // results are checked before the byte of the same edge is predicted
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_decoder();
      expected_pix_q.delete();
    end else begin
      if (out_tvalid && out_tready) check_result();
      if (in_tvalid && in_tready) decode_byte(in_tdata, in_tuser);
    end
    pending = expected_pix_q.size();
  end

endmodule

FILE: bench/tb_diff_huffman_image_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_diff_huffman_image_decoder
// Feeds compressed image files (directed corner files, then random files
// and noise) into the decoder under random stalls; the scoreboard checks.
// ----------------------------------------------------------------------------
module tb_diff_huffman_image_decoder;

  localparam int TARGET_BYTES = 310;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;    // data_byte
  logic       in_tuser;    // start_of_file
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;   // pixel
  logic [2:0] out_tuser;   // status[1:0], image_done[2]
  logic       out_tlast;   // last_of_run
  int         errors;
  int         pending;
  int         send_idle_pct;
  int         recv_idle_pct;

  logic [8:0] file_byte_q[$];  // {start_of_file, data_byte}
  logic       bit_q[$];

  diff_huffman_image_decoder dut (.*);

  dhid_scoreboard u_scoreboard (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) out_tready <= ($urandom_range(99) >= recv_idle_pct);

  task automatic put_bits(logic [31:0] v, int n);
    for (int i = n - 1; i >= 0; i--) bit_q.insert(bit_q.size(), v[i]);
  endtask

  // mode 0: random codes, 1: first entry of length 0, 2: one code with no match
  task automatic add_file(logic [31:0] w, logic [31:0] h, int cnt, int maxlen, int mode);
    int          lens[$];
    logic [31:0] codes[$];
    logic [31:0] nc;
    int          cl, npix, j;
    logic [7:0]  b;
    for (int i = 0; i < 8; i++)
      file_byte_q.insert(file_byte_q.size(), {i == 0, 8'($urandom_range(255))});
    for (int i = 0; i < 4; i++) file_byte_q.insert(file_byte_q.size(), {1'b0, w[8*i +: 8]});
    for (int i = 0; i < 4; i++) file_byte_q.insert(file_byte_q.size(), {1'b0, h[8*i +: 8]});
    bit_q.delete();
    put_bits(cnt, 9);
    for (int i = 0; i < cnt; i++)
      lens.insert(lens.size(), mode == 2 ? maxlen : int'($urandom_range(maxlen, 1)));
    lens.sort();
    if (mode == 1) lens[0] = 0;
    nc = '0;
    cl = 0;
    foreach (lens[i]) begin
      while (cl < lens[i]) begin
        nc = nc << 1;
        cl++;
      end
      codes.insert(codes.size(), nc);
      nc++;
      put_bits($urandom_range(511), 9);
      put_bits(lens[i], 5);
    end
    npix = (w < 64 && h < 64) ? w * h : 0;
    for (int p = 0; p < npix && cnt > 0; p++) begin
      if (mode == 2 && p == npix / 2) put_bits('1, maxlen);
      j = $urandom_range(cnt - 1);
      put_bits(codes[j], lens[j]);
    end
    while (bit_q.size() % 8 != 0 || $urandom_range(3) == 0)
      bit_q.insert(bit_q.size(), 1'($urandom_range(1)));
    while (bit_q.size() > 0) begin
      for (int k = 7; k >= 0; k--) b[k] = bit_q.pop_front();
      file_byte_q.insert(file_byte_q.size(), {1'b0, b});
    end
  endtask

  task automatic add_noise(int n);
    for (int i = 0; i < n; i++)
      file_byte_q.insert(file_byte_q.size(),
                         {$urandom_range(3) == 0, 8'($urandom_range(255))});
  endtask

  initial begin
    int total;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    send_idle_pct = 7;
    recv_idle_pct = 77;

    // directed files
    add_file(3, 2, 4, 3, 0);
    add_file(2, 2, 0, 1, 0);            // empty table, pixels pending
    add_file(1, 1, 1, 1, 1);            // one-symbol table, length 0
    add_file(32'hFFFF_FFFF, 0, 0, 1, 0); // zero height, full-scale width
    add_file(0, 32'hFFFF_FFFF, 0, 1, 0); // zero width
    add_file(4, 1, 2, 2, 2);            // code that matches nothing
    add_noise(3);

    // random files and noise
    while (file_byte_q.size() < TARGET_BYTES) begin
      case ($urandom_range(9))
        0: add_noise($urandom_range(4, 1));
        1: add_file($urandom_range(6, 1), $urandom_range(3, 1), $urandom_range(6, 1), 4, 2);
        2: add_file($urandom_range(3, 1), $urandom_range(2, 1), $urandom_range(3, 1), 3, 1);
        3: add_file($urandom_range(3), $urandom_range(3), $urandom_range(4), 3, 0);
        default: add_file($urandom_range(6, 1), $urandom_range(4, 1),
                          $urandom_range(12, 1), $urandom_range(6, 3), 0);
      endcase
    end
    total = file_byte_q.size();

    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < total; i++) begin
      if (i == total / 3) begin
        send_idle_pct = 77;
        recv_idle_pct = 7;
      end else if (i == 2 * total / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      while ($urandom_range(99) < send_idle_pct) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end
      in_tvalid <= 1'b1;
      {in_tuser, in_tdata} <= file_byte_q[i];
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      @(negedge clk);
    end
    in_tvalid <= 1'b0;

    // drain, then let any late work show up
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) $display("diff_huffman_image_decoder regression: pass");
    else $display("diff_huffman_image_decoder regression: fail");
    $finish;
  end

  initial begin
    #20000000;
    $display("diff_huffman_image_decoder regression: fail");
    $finish;
  end

endmodule
